### sv/lidar_packet_point_decoder_top_macros.svh
// ---------------------------------------------------------------------------
// Lidar packet point decoder assertion macros
// Shorthand for the concurrent checks of the decoder top level.
// ---------------------------------------------------------------------------
`ifndef LIDAR_PACKET_POINT_DECODER_TOP_MACROS_SVH
`define LIDAR_PACKET_POINT_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpd check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpd check failed");

`endif

### sv/lpd_pkg.sv
// ---------------------------------------------------------------------------
// Lidar packet point decoder package
// Shared constants, types and the CRC-8 step of the decoder.
// ---------------------------------------------------------------------------
package lpd_pkg;

  localparam logic [7:0] HdrFirst  = 8'h54;
  localparam logic [7:0] HdrSecond = 8'h2C;
  localparam logic [7:0] CrcSeed   = 8'hD8;
  localparam logic [7:0] CrcPoly   = 8'h4D;

  // Payload byte positions.
  localparam int unsigned StartLo    = 2;
  localparam int unsigned StartHi    = 3;
  localparam int unsigned PointFirst = 4;
  localparam int unsigned EndLo      = 40;
  localparam int unsigned EndHi      = 41;
  localparam int unsigned CrcIndex   = 44;

  localparam int unsigned NumPoints  = 12;
  localparam int unsigned NumBanks   = 2;
  localparam int unsigned QueueDepth = NumBanks;
  localparam int unsigned StoreDepth = NumBanks * NumPoints;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned PtIdxW     = $clog2(NumPoints);
  localparam int unsigned CntW       = 6;

  localparam int unsigned FullTurn   = 36000;
  // floor(x / 11) == (x * StepRecip) >> StepShift for every x below 36000.
  localparam int unsigned StepRecip  = 47663;
  localparam int unsigned StepShift  = 19;
  localparam int unsigned DiffW      = 18;
  localparam int unsigned StepW      = 32 - StepShift;

  typedef struct packed {
    logic        bank;
    logic [15:0] start_angle;
    logic [15:0] end_angle;
  } frame_desc_t;

  typedef struct packed {
    logic             dist_we;
    logic             inten_we;
    logic [AddrW-1:0] addr;
    logic [15:0]      distance;
    logic [7:0]       inten;
  } store_wr_t;

  typedef struct packed {
    logic active;
    logic release_en;
    logic release_bank;
  } back_status_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [AddrW-1:0] store_addr(logic bank, logic [PtIdxW-1:0] idx);
    return AddrW'(idx) + (bank ? AddrW'(NumPoints) : AddrW'(0));
  endfunction

endpackage

### sv/lpd_front.sv
// ---------------------------------------------------------------------------
// Lidar packet point decoder front end
// Hunts for the header, checks the CRC and fills one point bank per frame.
// ---------------------------------------------------------------------------
module lpd_front
  import lpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         rx_valid_i,
  input  logic [7:0]   rx_byte_i,
  output logic         rx_stall_o,
  output store_wr_t    store_wr_o,
  output logic         push_o,
  output frame_desc_t  push_desc_o,
  input  back_status_t back_status_i
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_GOT_T   = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          low_q, low_d;
  logic [15:0]         start_q, start_d;
  logic [15:0]         end_q, end_d;
  logic [PtIdxW-1:0]   idx_q, idx_d;
  logic [1:0]          pos_q, pos_d;
  logic                bank_q, bank_d;
  logic [NumBanks-1:0] busy_q, busy_d;
  logic                accept;

  assign rx_stall_o  = (phase_q == PH_PAYLOAD) && busy_q[bank_q];
  assign accept      = rx_valid_i && !rx_stall_o;
  assign push_desc_o = '{bank: bank_q, start_angle: start_q, end_angle: end_q};

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    low_d      = low_q;
    start_d    = start_q;
    end_d      = end_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    push_o     = 1'b0;
    store_wr_o = '{dist_we: 1'b0, inten_we: 1'b0, addr: store_addr(bank_q, idx_q),
                   distance: {rx_byte_i, low_q}, inten: rx_byte_i};
    if (back_status_i.release_en) begin
      busy_d[back_status_i.release_bank] = 1'b0;
    end
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == HdrFirst) begin
            phase_d = PH_GOT_T;
          end
        end
        PH_GOT_T: begin
          if (rx_byte_i == HdrSecond) begin
            phase_d = PH_PAYLOAD;
            cnt_d   = '0;
            crc_d   = CrcSeed;
            idx_d   = '0;
            pos_d   = '0;
          end else if (rx_byte_i != HdrFirst) begin
            phase_d = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (cnt_q == CntW'(CrcIndex)) begin
            if (rx_byte_i == crc_q) begin
              push_o         = 1'b1;
              busy_d[bank_q] = 1'b1;
              bank_d         = !bank_q;
            end
            phase_d = PH_HUNT;
            cnt_d   = '0;
            crc_d   = CrcSeed;
          end else begin
            crc_d = crc8_update(crc_q, rx_byte_i);
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == CntW'(StartLo) || cnt_q == CntW'(EndLo)) begin
              low_d = rx_byte_i;
            end else if (cnt_q == CntW'(StartHi)) begin
              start_d = {rx_byte_i, low_q};
            end else if (cnt_q == CntW'(EndHi)) begin
              end_d = {rx_byte_i, low_q};
            end else if (cnt_q >= CntW'(PointFirst) && cnt_q < CntW'(EndLo)) begin
              case (pos_q)
                2'd0: begin
                  low_d = rx_byte_i;
                  pos_d = 2'd1;
                end
                2'd1: begin
                  store_wr_o.dist_we = 1'b1;
                  pos_d              = 2'd2;
                end
                default: begin
                  store_wr_o.inten_we = 1'b1;
                  pos_d               = 2'd0;
                  idx_d               = idx_q + PtIdxW'(1);
                end
              endcase
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      crc_q   <= CrcSeed;
      idx_q   <= '0;
      pos_q   <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule

### sv/lpd_fifo.sv
// ---------------------------------------------------------------------------
// Lidar packet point decoder frame queue
// Short queue of good-frame descriptors between the front and back ends.
// ---------------------------------------------------------------------------
module lpd_fifo
  import lpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_desc_t push_desc_i,
  input  logic        pop_i,
  output frame_desc_t pop_desc_o,
  output logic        empty_o,
  output logic        full_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  frame_desc_t       mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CountW'(QueueDepth));
  assign pop_desc_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CountW'(push_i) - CountW'(pop_i);
    end
  end

endmodule

### sv/lpd_back.sv
// ---------------------------------------------------------------------------
// Lidar packet point decoder back end
// Holds the point banks, works out the angle step and emits twelve points.
// ---------------------------------------------------------------------------
module lpd_back
  import lpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  store_wr_t    store_wr_i,
  input  logic         q_empty_i,
  input  frame_desc_t  q_desc_i,
  output logic         q_pop_o,
  output back_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [15:0]  distance_mm_o,
  output logic [7:0]   intensity_o,
  output logic [15:0]  angle_centideg_o,
  output logic         last_point_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_SPAN = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  logic [15:0] dist_mem [StoreDepth];
  logic [7:0]  inten_mem [StoreDepth];

  state_e            state_q, state_d;
  frame_desc_t       desc_q;
  logic [DiffW-1:0]  diff_q;
  logic [15:0]       astart_q;
  logic [15:0]       span_q;
  logic [31:0]       prod_q;
  logic [15:0]       acc_q;
  logic [PtIdxW-1:0] idx_q;
  logic              out_valid_q;
  logic [15:0]       dist_q;
  logic [7:0]        inten_q;
  logic [15:0]       angle_q;
  logic              last_q;

  logic              load;
  logic              is_last;
  logic [AddrW-1:0]  rd_addr;
  logic [16:0]       acc_sum;
  logic [15:0]       acc_next;
  logic [15:0]       span_next;

  assign load    = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == PtIdxW'(NumPoints - 1));
  assign rd_addr = store_addr(desc_q.bank, idx_q);
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign acc_sum = {1'b0, acc_q} + 17'(prod_q[31:StepShift]);
  assign acc_next = (acc_sum >= 17'(FullTurn)) ? 16'(acc_sum - 17'(FullTurn))
                                                 : acc_sum[15:0];

  assign status_o = '{active: (state_q != S_IDLE), release_en: load && is_last,
                      release_bank: desc_q.bank};

  always_comb begin
    if (diff_q >= DiffW'(3 * FullTurn)) begin
      span_next = 16'(diff_q - DiffW'(3 * FullTurn));
    end else if (diff_q >= DiffW'(2 * FullTurn)) begin
      span_next = 16'(diff_q - DiffW'(2 * FullTurn));
    end else if (diff_q >= DiffW'(FullTurn)) begin
      span_next = 16'(diff_q - DiffW'(FullTurn));
    end else begin
      span_next = diff_q[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_SPAN;
      S_SPAN: state_d = S_MUL;
      S_MUL:  state_d = S_EMIT;
      S_EMIT: begin
        if (load && is_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store_wr_i.dist_we) begin
      dist_mem[store_wr_i.addr] <= store_wr_i.distance;
    end
    if (store_wr_i.inten_we) begin
      inten_mem[store_wr_i.addr] <= store_wr_i.inten;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      desc_q <= q_desc_i;
    end
    if (state_q == S_DIFF) begin
      diff_q   <= DiffW'(desc_q.end_angle) + DiffW'(2 * FullTurn)
                  - DiffW'(desc_q.start_angle);
      astart_q <= (desc_q.start_angle >= 16'(FullTurn))
                  ? desc_q.start_angle - 16'(FullTurn) : desc_q.start_angle;
    end
    if (state_q == S_SPAN) begin
      span_q <= span_next;
    end
    if (state_q == S_MUL) begin
      prod_q <= 32'(span_q) * 32'(StepRecip);
      acc_q  <= astart_q;
    end
    if (load) begin
      dist_q  <= dist_mem[rd_addr];
      inten_q <= inten_mem[rd_addr];
      angle_q <= acc_q;
      last_q  <= is_last;
      acc_q   <= acc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MUL) begin
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + PtIdxW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_mm_o    = dist_q;
  assign intensity_o      = inten_q;
  assign angle_centideg_o = angle_q;
  assign last_point_o     = last_q;

endmodule

### sv/lidar_packet_point_decoder_top.sv
// A byte is taken whenever rx_stall_o is low; the front end stalls
// a payload byte only while both point banks are still owned by the emitter,
// which happens only when frames arrive faster than their points are taken.
// A frame whose CRC matches yields twelve points: the emitter fetches the frame
// from the queue in S_IDLE and works out the angle span and step in S_DIFF,
// S_SPAN and S_MUL, and only then emits the first point; its single output
// register then delivers one point per cycle while out_stall_i stays low.
// The point banks need no clearing after reset.
// ---------------------------------------------------------------------------
// Lidar packet point decoder top level
// Parses framed lidar bytes and emits the twelve points of each good frame.
// ---------------------------------------------------------------------------
`include "lidar_packet_point_decoder_top_macros.svh"

module lidar_packet_point_decoder_top
  import lpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_byte_i,
  output logic        rx_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] distance_mm_o,
  output logic [7:0]  intensity_o,
  output logic [15:0] angle_centideg_o,
  output logic        last_point_o
);

  store_wr_t    store_wr;
  logic         q_push;
  frame_desc_t  q_push_desc;
  logic         q_pop;
  frame_desc_t  q_pop_desc;
  logic         q_empty;
  logic         q_full;
  back_status_t back_status;

  lpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_byte_i     (rx_byte_i),
    .rx_stall_o    (rx_stall_o),
    .store_wr_o    (store_wr),
    .push_o        (q_push),
    .push_desc_o   (q_push_desc),
    .back_status_i (back_status)
  );

  lpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (q_push_desc),
    .pop_i       (q_pop),
    .pop_desc_o  (q_pop_desc),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  lpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .store_wr_i       (store_wr),
    .q_empty_i        (q_empty),
    .q_desc_i         (q_pop_desc),
    .q_pop_o          (q_pop),
    .status_o         (back_status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .distance_mm_o    (distance_mm_o),
    .intensity_o      (intensity_o),
    .angle_centideg_o (angle_centideg_o),
    .last_point_o     (last_point_o)
  );

  `LPD_ASSERT_IMP(a_push_not_full, clk_i, rst_ni, q_push, !q_full)
  `LPD_ASSERT_IMP(a_pop_not_empty, clk_i, rst_ni, q_pop, !q_empty)
  `LPD_ASSERT_IMP(a_stall_has_owner, clk_i, rst_ni, rx_stall_o, !q_empty || back_status.active)
  `LPD_ASSERT_NEXT(a_release_idles, clk_i, rst_ni, back_status.release_en, !back_status.active)

endmodule

### verif/tb_lidar_packet_point_decoder_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Lidar packet point decoder testbench
// Feeds byte streams of whole, damaged and cut-off frames with random gaps and
// a long output hold-off. It decodes every accepted byte itself and checks
// each emitted point against the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_lidar_packet_point_decoder_top;
  import lpd_pkg::*;

  localparam int unsigned RandomItems = 170;
  localparam int unsigned MinGoodFrames = 3;
  localparam int unsigned AngleSteps = NumPoints - 1;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned CalmFirst = 100;
  localparam int unsigned CalmLast = 160;

  typedef enum logic [1:0] {SeekHeader, SawFirst, InPayload} parse_phase_e;
  typedef enum int {FillRandom, FillZero, FillOnes, FillHeader} fill_e;

  typedef struct packed {
    logic [15:0] distance;
    logic [7:0]  inten;
    logic [15:0] angle;
    logic        last;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        rx_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] distance_mm_o;
  logic [7:0]  intensity_o;
  logic [15:0] angle_centideg_o;
  logic        last_point_o;

  logic [7:0]  pending_bytes[$];
  point_t      expected_points[$];
  point_t      head_point;
  int unsigned bytes_taken = 0;
  int unsigned points_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  parse_phase_e phase_q = SeekHeader;
  int unsigned  pos_q = 0;
  logic [7:0]   crc_q = CrcSeed;
  logic [7:0]   low_q = 8'h00;
  logic [15:0]  start_q = 16'h0000;
  logic [15:0]  end_q = 16'h0000;
  logic [15:0]  dist_store[NumPoints];
  logic [7:0]   inten_store[NumPoints];

  lidar_packet_point_decoder_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_byte_i        (rx_byte_i),
    .rx_stall_o       (rx_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .distance_mm_o    (distance_mm_o),
    .intensity_o      (intensity_o),
    .angle_centideg_o (angle_centideg_o),
    .last_point_o     (last_point_o)
  );

  assign calm = (bytes_taken >= CalmFirst) && (bytes_taken < CalmLast);

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CrcPoly : 8'h00);
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    int unsigned span;
    int unsigned step;
    int unsigned rel;
    point_t pt;
    case (phase_q)
      SeekHeader: begin
        if (b == HdrFirst) phase_q = SawFirst;
      end
      SawFirst: begin
        if (b == HdrSecond) begin
          phase_q = InPayload;
          pos_q = 0;
          crc_q = CrcSeed;
        end else if (b != HdrFirst) begin
          phase_q = SeekHeader;
        end
      end
      default: begin
        if (pos_q == CrcIndex) begin
          if (b == crc_q) begin
            span = (32'(end_q) + 2 * FullTurn - 32'(start_q)) % FullTurn;
            step = span / AngleSteps;
            for (int i = 0; i < NumPoints; i++) begin
              pt.distance = dist_store[i];
              pt.inten = inten_store[i];
              pt.angle = 16'((32'(start_q) + step * i) % FullTurn);
              pt.last = (i == NumPoints - 1);
              expected_points.push_back(pt);
            end
          end
          phase_q = SeekHeader;
          pos_q = 0;
          crc_q = CrcSeed;
        end else begin
          crc_q = crc8_next(crc_q, b);
          if (pos_q == StartLo || pos_q == EndLo) begin
            low_q = b;
          end else if (pos_q == StartHi) begin
            start_q = {b, low_q};
          end else if (pos_q == EndHi) begin
            end_q = {b, low_q};
          end else if (pos_q >= PointFirst && pos_q < EndLo) begin
            rel = pos_q - PointFirst;
            case (rel % 3)
              0: low_q = b;
              1: dist_store[rel / 3] = {b, low_q};
              default: inten_store[rel / 3] = b;
            endcase
          end
          pos_q++;
        end
      end
    endcase
  endtask

  task automatic queue_frame(input logic [15:0] start_ang, input logic [15:0] end_ang,
                             input fill_e fill, input bit bad_crc);
    logic [7:0] body[CrcIndex];
    logic [7:0] crc;
    foreach (body[k]) body[k] = 8'($urandom);
    for (int k = PointFirst; k < EndLo; k++) begin
      case (fill)
        FillZero: body[k] = 8'h00;
        FillOnes: body[k] = 8'hFF;
        FillHeader: body[k] = k[0] ? HdrSecond : HdrFirst;
        default: ;
      endcase
    end
    body[StartLo] = start_ang[7:0];
    body[StartHi] = start_ang[15:8];
    body[EndLo] = end_ang[7:0];
    body[EndHi] = end_ang[15:8];
    crc = CrcSeed;
    foreach (body[k]) crc = crc8_next(crc, body[k]);
    if (bad_crc) crc ^= 8'(1 << $urandom_range(7));
    pending_bytes.push_back(HdrFirst);
    pending_bytes.push_back(HdrSecond);
    foreach (body[k]) pending_bytes.push_back(body[k]);
    pending_bytes.push_back(crc);
  endtask

  task automatic queue_noise(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(5);
      pending_bytes.push_back(pick < 2 ? HdrFirst : pick == 2 ? HdrSecond : 8'($urandom));
    end
  endtask

  function automatic logic [15:0] random_angle();
    return ($urandom_range(99) < 85) ? 16'($urandom_range(FullTurn - 1)) : 16'($urandom);
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
    end else begin
      if (rx_valid_i && !rx_stall_o) begin
        parse_rx_byte(rx_byte_i);
        bytes_taken++;
      end
      if (!rx_valid_i || !rx_stall_o) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          rx_valid_i <= 1'b1;
          rx_byte_i <= pending_bytes.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && points_seen != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point: distance %0d intensity %0d angle %0d last %0b",
                 $time, distance_mm_o, intensity_o, angle_centideg_o, last_point_o);
        fail_count++;
      end else begin
        head_point = expected_points.pop_front();
        if (distance_mm_o !== head_point.distance) begin
          $display("%0t: distance_mm expected %0d actual %0d",
                   $time, head_point.distance, distance_mm_o);
          fail_count++;
        end
        if (intensity_o !== head_point.inten) begin
          $display("%0t: intensity expected %0d actual %0d",
                   $time, head_point.inten, intensity_o);
          fail_count++;
        end
        if (angle_centideg_o !== head_point.angle) begin
          $display("%0t: angle_centideg expected %0d actual %0d",
                   $time, head_point.angle, angle_centideg_o);
          fail_count++;
        end
        if (last_point_o !== head_point.last) begin
          $display("%0t: last_point expected %0b actual %0b",
                   $time, head_point.last, last_point_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned good_frames;
    good_frames = 0;

    // A lone comma and a broken header are ignored; repeated 'T' keeps the match.
    pending_bytes.push_back(HdrSecond);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(HdrFirst);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(HdrSecond);
    pending_bytes.push_back(HdrFirst);
    pending_bytes.push_back(HdrFirst);
    queue_frame(16'(FullTurn - 1), 16'd0, FillOnes, 1'b0);
    queue_frame(16'hFFFF, 16'd40000, FillHeader, 1'b0);
    good_frames = 2;
    queue_frame(16'd40000, 16'd100, FillRandom, 1'b1);

    while (pending_bytes.size() < RandomItems || good_frames < MinGoodFrames) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_frame(random_angle(), random_angle(),
                    ($urandom_range(9) < 7) ? FillRandom : fill_e'($urandom_range(3)), 1'b0);
        good_frames++;
      end else if (pick < 80) begin
        queue_frame(random_angle(), random_angle(), FillRandom, 1'b1);
      end else if (pick < 90) begin
        queue_noise($urandom_range(1, 6));
      end else begin
        // A cut-off frame swallows whatever follows as payload.
        pending_bytes.push_back(HdrFirst);
        pending_bytes.push_back(HdrSecond);
        repeat ($urandom_range(1, CrcIndex - 1)) pending_bytes.push_back(8'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_bytes.size() != 0 || rx_valid_i) @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/lpd_pkg.sv
sv/lpd_front.sv
sv/lpd_fifo.sv
sv/lpd_back.sv
sv/lidar_packet_point_decoder_top.sv
verif/tb_lidar_packet_point_decoder_top.sv
